// ===== sv/itdt_pkg.sv =====
`timescale 1ns / 1ps

package itdt_pkg;

  localparam int MAX_DIGITS      = 10;
  localparam int DIGIT_W         = 4;
  localparam int VALUE_W         = 32;
  localparam int CAP_W           = 16;
  localparam int CHAR_W          = 8;
  localparam int CNT_W           = 4;
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    digit_t [MAX_DIGITS-1:0] digits;
    logic [CNT_W-1:0]        count;
    logic                    negative;
    logic                    failed;
  } conv_t;

endpackage

// ===== sv/itdt_if.sv =====
`timescale 1ns / 1ps

interface itdt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [itdt_pkg::VALUE_W-1:0] value;
  logic [itdt_pkg::CAP_W-1:0]          buffer_length;

  modport source (output valid, value, buffer_length, input ready);
  modport sink (input valid, value, buffer_length, output ready);
endinterface

interface itdt_out_if;
  logic                        valid;
  logic                        ready;
  logic [itdt_pkg::CHAR_W-1:0] character;
  logic                        last;
  logic                        failed;

  modport source (output valid, character, last, failed, input ready);
  modport sink (input valid, character, last, failed, output ready);
endinterface

// ===== sv/integer_to_decimal_text.sv =====
`timescale 1ns / 1ps
// An accepted beat passes the input register, the double-dabble stages and
// the count register; the serializer then emits one character per cycle
// while out_o.ready is high: any minus sign, then digits, or one error beat.
// The double-dabble pipeline accepts a beat every cycle when unstalled.
// Reset: asynchronous, active low; clears all valid bits, no item is held.

module integer_to_decimal_text (
  input  logic       clk_i,
  input  logic       rst_ni,
  itdt_in_if.sink    in_i,
  itdt_out_if.source out_o
);
  import itdt_pkg::*;

  logic             conv_valid;
  logic             conv_ready;
  conv_t            conv;

  logic             busy_q;
  logic             fail_q;
  logic             sign_q;
  logic [CNT_W-1:0] idx_q;
  digit_t           dig_q [MAX_DIGITS];

  logic             last_w;
  logic             take;
  logic             load;

  itdt_bcd_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .conv_valid_o (conv_valid),
    .conv_ready_i (conv_ready),
    .conv_o       (conv)
  );

  assign last_w     = fail_q || (!sign_q && (idx_q == '0));
  assign take       = busy_q && out_o.ready;
  assign conv_ready = !busy_q || (out_o.ready && last_w);
  assign load       = conv_ready && conv_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      fail_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      fail_q <= conv.failed;
      sign_q <= conv.negative;
      idx_q  <= conv.count - CNT_W'(1);
    end else if (take) begin
      if (last_w) begin
        busy_q <= 1'b0;
      end else if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        idx_q <= idx_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig_q[i] <= conv.digits[i];
      end
    end
  end

  assign out_o.valid  = busy_q;
  assign out_o.last   = last_w;
  assign out_o.failed = fail_q;

  always_comb begin
    if (fail_q) begin
      out_o.character = CHAR_NUL;
    end else if (sign_q) begin
      out_o.character = CHAR_MINUS;
    end else begin
      out_o.character = CHAR_ZERO + CHAR_W'(dig_q[idx_q]);
    end
  end

endmodule

// ===== sv/itdt_bcd_pipe.sv =====
`timescale 1ns / 1ps

module itdt_bcd_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  itdt_in_if.sink         in_i,
  output logic            conv_valid_o,
  input  logic            conv_ready_i,
  output itdt_pkg::conv_t conv_o
);
  import itdt_pkg::*;

  localparam int BcdW    = MAX_DIGITS * DIGIT_W;
  localparam int DabStgs = VALUE_W / STEPS_PER_STAGE;

  logic                 vld_q [0:DabStgs];
  logic                 en    [0:DabStgs];
  logic [BcdW-1:0]      bcd_q [0:DabStgs];
  logic [VALUE_W-1:0]   bin_q [0:DabStgs];
  logic                 neg_q [0:DabStgs];
  logic [CAP_W-1:0]     cap_q [0:DabStgs];

  logic                 cnt_en;
  logic                 cnt_vld_q;
  conv_t                conv_d, conv_q;

  assign cnt_en     = !cnt_vld_q || conv_ready_i;
  assign in_i.ready = en[0];

  for (genvar s = 0; s <= DabStgs; s++) begin : g_en
    if (s == DabStgs) begin : g_tail
      assign en[s] = !vld_q[s] || cnt_en;
    end else begin : g_body
      assign en[s] = !vld_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en[0]) begin
      vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg_q[0] <= in_i.value[VALUE_W-1];
      bin_q[0] <= in_i.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_i.value))
                                         : VALUE_W'(in_i.value);
      bcd_q[0] <= '0;
      cap_q[0] <= in_i.buffer_length;
    end
  end

  for (genvar s = 1; s <= DabStgs; s++) begin : g_dab
    logic [BcdW-1:0]    bcd_d;
    logic [VALUE_W-1:0] bin_d;

    always_comb begin
      logic [BcdW-1:0]    b;
      logic [VALUE_W-1:0] m;
      b = bcd_q[s-1];
      m = bin_q[s-1];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (b[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            b[i*DIGIT_W +: DIGIT_W] = b[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
          end
        end
        b = {b[BcdW-2:0], m[VALUE_W-1]};
        m = {m[VALUE_W-2:0], 1'b0};
      end
      bcd_d = b;
      bin_d = m;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en[s]) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        bcd_q[s] <= bcd_d;
        bin_q[s] <= bin_d;
        neg_q[s] <= neg_q[s-1];
        cap_q[s] <= cap_q[s-1];
      end
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [CNT_W:0]   total;
    cnt = CNT_W'(1);
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (bcd_q[DabStgs][i*DIGIT_W +: DIGIT_W] != '0) begin
        cnt = CNT_W'(i + 1);
      end
    end
    total           = {1'b0, cnt} + (CNT_W+1)'(neg_q[DabStgs]);
    conv_d.digits   = bcd_q[DabStgs];
    conv_d.count    = cnt;
    conv_d.negative = neg_q[DabStgs];
    conv_d.failed   = (cap_q[DabStgs] == '0) || (CAP_W'(total) >= cap_q[DabStgs]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= 1'b0;
    end else if (cnt_en) begin
      cnt_vld_q <= vld_q[DabStgs];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_en) begin
      conv_q <= conv_d;
    end
  end

  assign conv_valid_o = cnt_vld_q;
  assign conv_o       = conv_q;

endmodule
